FILE: rtl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared constants, types and helpers of the fingerprint command framer.
// ----------------------------------------------------------------------------
package fcf_pkg;

    localparam int PACKET_BUFFER_BYTES = 32;
    localparam int OVERHEAD_BYTES      = 12;
    localparam int MAX_PAYLOAD         = PACKET_BUFFER_BYTES - OVERHEAD_BYTES;
    localparam int POS_W               = $clog2(MAX_PAYLOAD + 1);

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 32;
    localparam int SUM_W  = 16;

    localparam logic [SUM_W-1:0]  HEADER_WORD   = 16'hEF01;
    localparam logic [BYTE_W-1:0] PACKET_ID_CMD = 8'h01;
    localparam logic [SUM_W-1:0]  LENGTH_EXTRA  = 16'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // header byte slots
    localparam int HDR_W = 4;
    localparam logic [HDR_W-1:0] HDR_SYNC_HI = 4'd0;
    localparam logic [HDR_W-1:0] HDR_SYNC_LO = 4'd1;
    localparam logic [HDR_W-1:0] HDR_ADDR_3  = 4'd2;
    localparam logic [HDR_W-1:0] HDR_ADDR_2  = 4'd3;
    localparam logic [HDR_W-1:0] HDR_ADDR_1  = 4'd4;
    localparam logic [HDR_W-1:0] HDR_ADDR_0  = 4'd5;
    localparam logic [HDR_W-1:0] HDR_ID      = 4'd6;
    localparam logic [HDR_W-1:0] HDR_LEN_HI  = 4'd7;
    localparam logic [HDR_W-1:0] HDR_LEN_LO  = 4'd8;
    localparam logic [HDR_W-1:0] HDR_CMD     = 4'd9;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        K_ERROR = 2'd0,
        K_FIRST = 2'd1,
        K_DATA  = 2'd2
    } t_kind;

    // one queued job for the back end
    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  cmd;
        logic [SUM_W-1:0]   len_field;
        logic               has_data;
        logic [BYTE_W-1:0]  data;
        logic               do_csum;
        logic [SUM_W-1:0]   csum;
    } t_entry;

    function automatic logic [BYTE_W-1:0] hdr_byte(
        input logic [HDR_W-1:0]  idx,
        input logic [ADDR_W-1:0] addr,
        input logic [SUM_W-1:0]  len_field,
        input logic [BYTE_W-1:0] cmd
    );
        logic [BYTE_W-1:0] b;
        case (idx)
            HDR_SYNC_HI: b = HEADER_WORD[15:8];
            HDR_SYNC_LO: b = HEADER_WORD[7:0];
            HDR_ADDR_3:  b = addr[31:24];
            HDR_ADDR_2:  b = addr[23:16];
            HDR_ADDR_1:  b = addr[15:8];
            HDR_ADDR_0:  b = addr[7:0];
            HDR_ID:      b = PACKET_ID_CMD;
            HDR_LEN_HI:  b = len_field[15:8];
            HDR_LEN_LO:  b = len_field[7:0];
            HDR_CMD:     b = cmd;
            default:     b = '0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/fcf_ifs.sv
// ----------------------------------------------------------------------------
// fcf_ifs
// Valid/ready channels of the framer: item input, byte output, address write.
// ----------------------------------------------------------------------------
interface fcf_in_if import fcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] payload_len;
    logic [BYTE_W-1:0] reply_len;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, command_code, payload_len, reply_len, data_byte,
                    input ready);
    modport sink   (input valid, command_code, payload_len, reply_len, data_byte,
                    output ready);
endinterface

interface fcf_out_if import fcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              error;

    modport source (output valid, out_byte, last, error, input ready);
    modport sink   (input valid, out_byte, last, error, output ready);
endinterface

interface fcf_cfg_if import fcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/fcf_front.sv
// ----------------------------------------------------------------------------
// fcf_front
// Accepts items, checks sizes, tracks position and checksum, queues jobs.
// ----------------------------------------------------------------------------
module fcf_front import fcf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fcf_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_entry   o_entry
);

    t_pos             r_pos, n_pos;
    t_pos             r_len, n_len;
    logic [SUM_W-1:0] r_sum, n_sum;

    logic [SUM_W-1:0] len_field;
    logic [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0] base_sum;
    logic [SUM_W-1:0] data_sum;
    t_pos             pos_inc;
    logic             too_big;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        len_field = SUM_W'(i_in.payload_len) + LENGTH_EXTRA;
        head_sum  = SUM_W'(PACKET_ID_CMD) + SUM_W'(len_field[15:8])
                  + SUM_W'(len_field[7:0]) + SUM_W'(i_in.command_code);
        too_big   = (i_in.payload_len > BYTE_W'(MAX_PAYLOAD))
                 || (i_in.reply_len > BYTE_W'(MAX_PAYLOAD));
        base_sum  = (r_pos == '0) ? head_sum : r_sum;
        data_sum  = base_sum + SUM_W'(i_in.data_byte);
        pos_inc   = r_pos + t_pos'(1);

        n_pos = r_pos;
        n_len = r_len;
        n_sum = r_sum;

        o_entry           = '0;
        o_entry.cmd       = i_in.command_code;
        o_entry.len_field = len_field;
        o_entry.data      = i_in.data_byte;

        if (r_pos == '0) begin
            if (too_big) begin
                o_entry.kind = K_ERROR;
            end else if (i_in.payload_len == '0) begin
                o_entry.kind    = K_FIRST;
                o_entry.do_csum = 1'b1;
                o_entry.csum    = head_sum;
            end else begin
                o_entry.kind     = K_FIRST;
                o_entry.has_data = 1'b1;
                o_entry.csum     = data_sum;
                if (t_pos'(1) >= i_in.payload_len[POS_W-1:0]) begin
                    o_entry.do_csum = 1'b1;
                end else begin
                    n_pos = t_pos'(1);
                    n_len = i_in.payload_len[POS_W-1:0];
                    n_sum = data_sum;
                end
            end
        end else begin
            o_entry.kind     = K_DATA;
            o_entry.has_data = 1'b1;
            o_entry.csum     = data_sum;
            if (pos_inc >= r_len) begin
                // packet complete: back to idle
                o_entry.do_csum = 1'b1;
                n_pos = '0;
                n_len = '0;
                n_sum = '0;
            end else begin
                n_pos = pos_inc;
                n_sum = data_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_sum <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_sum <= n_sum;
        end
    end

endmodule

FILE: rtl/fcf_queue.sv
// ----------------------------------------------------------------------------
// fcf_queue
// Small job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module fcf_queue import fcf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/fcf_back.sv
// ----------------------------------------------------------------------------
// fcf_back
// Walks each queued job byte by byte into a registered output word.
// ----------------------------------------------------------------------------
module fcf_back import fcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_q_valid,
    input  t_entry            i_head,
    output logic              o_pop,
    fcf_out_if.source         o_out
);

    typedef enum logic [3:0] {
        PH_HEAD   = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_SUM_HI = 4'b0100,
        PH_SUM_LO = 4'b1000
    } t_phase;

    logic              r_active, n_active;
    t_phase            r_phase, n_phase;
    logic [HDR_W-1:0]  r_idx, n_idx;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_err, n_err;

    t_phase            cur_phase;
    logic [HDR_W-1:0]  cur_idx;
    logic              load;
    logic              emit;

    assign load = !r_valid || o_out.ready;
    assign emit = load && i_q_valid;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;
    assign o_out.error    = r_err;

    always_comb begin
        if (r_active) begin
            cur_phase = r_phase;
            cur_idx   = r_idx;
        end else begin
            cur_phase = (i_head.kind == K_DATA) ? PH_DATA : PH_HEAD;
            cur_idx   = HDR_SYNC_HI;
        end

        n_active = 1'b1;
        n_phase  = cur_phase;
        n_idx    = cur_idx;
        n_byte   = '0;
        n_last   = 1'b0;
        n_err    = 1'b0;
        o_pop    = 1'b0;

        if (i_head.kind == K_ERROR) begin
            n_last   = 1'b1;
            n_err    = 1'b1;
            n_active = 1'b0;
            o_pop    = emit;
        end else begin
            case (cur_phase)
                PH_HEAD: begin
                    n_byte = hdr_byte(cur_idx, i_addr, i_head.len_field, i_head.cmd);
                    if (cur_idx == HDR_CMD) begin
                        n_phase = i_head.has_data ? PH_DATA : PH_SUM_HI;
                    end else begin
                        n_idx = cur_idx + HDR_W'(1);
                    end
                end
                PH_DATA: begin
                    n_byte = i_head.data;
                    if (i_head.do_csum) begin
                        n_phase = PH_SUM_HI;
                    end else begin
                        n_active = 1'b0;
                        o_pop    = emit;
                    end
                end
                PH_SUM_HI: begin
                    n_byte  = i_head.csum[15:8];
                    n_phase = PH_SUM_LO;
                end
                PH_SUM_LO: begin
                    n_byte   = i_head.csum[7:0];
                    n_last   = 1'b1;
                    n_active = 1'b0;
                    o_pop    = emit;
                end
                default: begin
                    n_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= PH_HEAD;
            r_idx    <= '0;
            r_valid  <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (emit) begin
                r_active <= n_active;
                r_phase  <= n_phase;
                r_idx    <= n_idx;
            end
        end
    end

    // hold the word until taken
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_last <= n_last;
            r_err  <= n_err;
        end
    end

endmodule

FILE: rtl/fingerprint_command_framer.sv
// A first item is queued as a job, then its first byte goes to the output register.
// One output word per cycle while the receiver is ready and a job waits; a rejected
// first item yields a lone error word, any other its ten header bytes, then its data
// byte, checksum or both; each further item its data byte (and the checksum if last).
// Input items are taken every cycle until the 4-entry job queue is full.
// Reset (synchronous, active low) empties queue and output, returns to idle
// and sets the device address to 0xFFFFFFFF.
// ----------------------------------------------------------------------------
// fingerprint_command_framer
// Frames command packets: header, address, id, length, command, payload, sum.
// ----------------------------------------------------------------------------
module fingerprint_command_framer import fcf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcf_cfg_if.sink    i_cfg,
    fcf_in_if.sink     i_in,
    fcf_out_if.source  o_out
);

    logic [ADDR_W-1:0] r_addr;
    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    t_entry            push_entry;
    t_entry            head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '1;
        end else if (i_cfg.valid) begin
            r_addr <= i_cfg.data;
        end
    end

    fcf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    fcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    fcf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_addr    (r_addr),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/fcf_checker.sv
// ----------------------------------------------------------------------------
// fcf_checker
// Port-level checks of the framer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module fcf_checker import fcf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_last,
    input logic              i_out_error
);

    logic r_at_start;
    logic out_take;

    assign out_take = i_out_valid && i_out_ready;

    // track packet boundaries on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else if (out_take) begin
            r_at_start <= i_out_last;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_err_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> i_out_last && (i_out_byte == '0))
        else $error("error word not a lone zero last word");

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> r_at_start)
        else $error("error word inside a packet");

    a_sync_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_at_start && !i_out_error |-> i_out_byte == HEADER_WORD[15:8])
        else $error("packet does not open with the sync byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled output word changed");

endmodule

bind fingerprint_command_framer fcf_checker u_fcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last),
    .i_out_error (o_out.error)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fingerprint_command_framer. Command items are fed
// from a queue through a valid/ready driver; a predictor frames every accepted
// item into expected packet words, and the output monitor compares each word
// field by field. The device address is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcf_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] payload_len;
        logic [BYTE_W-1:0] reply_len;
        logic [BYTE_W-1:0] data_byte;
    } t_cmd_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              error;
    } t_frame_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fcf_cfg_if cfg_ch ();
    fcf_in_if  in_ch ();
    fcf_out_if out_ch ();

    fingerprint_command_framer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cmd_item   pending_items[$];
    t_frame_word expected_words[$];

    // predictor copy of the framer state
    logic [ADDR_W-1:0] module_addr = '1;
    t_pos              pkt_pos     = '0;
    t_pos              pkt_len     = '0;
    logic [SUM_W-1:0]  pkt_sum     = '0;

    int   errors       = 0;
    int   inputs_taken = 0;
    logic in_taken     = 1'b0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    logic quiet;

    assign quiet = (inputs_taken >= 160) && (inputs_taken < 220);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("fingerprint_command_framer test failed");
        $finish;
    end

    task automatic queue_word(input logic [BYTE_W-1:0] b, input logic l, input logic e);
        expected_words.push_back('{out_byte: b, last: l, error: e});
    endtask

    task automatic queue_checksum();
        queue_word(pkt_sum[15:8], 1'b0, 1'b0);
        queue_word(pkt_sum[7:0], 1'b1, 1'b0);
        pkt_pos = '0;
        pkt_len = '0;
    endtask

    task automatic frame_item(input t_cmd_item it);
        logic [SUM_W-1:0] len_field;
        if (pkt_pos == '0) begin
            if (OVERHEAD_BYTES + it.payload_len > PACKET_BUFFER_BYTES ||
                OVERHEAD_BYTES + it.reply_len > PACKET_BUFFER_BYTES) begin
                queue_word('0, 1'b1, 1'b1);
                return;
            end
            len_field = LENGTH_EXTRA + it.payload_len;
            queue_word(HEADER_WORD[15:8], 1'b0, 1'b0);
            queue_word(HEADER_WORD[7:0], 1'b0, 1'b0);
            queue_word(module_addr[31:24], 1'b0, 1'b0);
            queue_word(module_addr[23:16], 1'b0, 1'b0);
            queue_word(module_addr[15:8], 1'b0, 1'b0);
            queue_word(module_addr[7:0], 1'b0, 1'b0);
            queue_word(PACKET_ID_CMD, 1'b0, 1'b0);
            queue_word(len_field[15:8], 1'b0, 1'b0);
            queue_word(len_field[7:0], 1'b0, 1'b0);
            queue_word(it.command_code, 1'b0, 1'b0);
            pkt_sum = SUM_W'(PACKET_ID_CMD) + len_field[15:8] + len_field[7:0]
                      + it.command_code;
            pkt_len = it.payload_len[POS_W-1:0];
            if (it.payload_len == '0) begin
                queue_checksum();
                return;
            end
        end
        queue_word(it.data_byte, 1'b0, 1'b0);
        pkt_sum = pkt_sum + it.data_byte;
        pkt_pos = pkt_pos + 1'b1;
        if (pkt_pos >= pkt_len)
            queue_checksum();
    endtask

    // input side: predict every accepted word
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            frame_item('{command_code: in_ch.command_code, payload_len: in_ch.payload_len,
                         reply_len: in_ch.reply_len, data_byte: in_ch.data_byte});
            inputs_taken <= inputs_taken + 1;
        end
    end

    // output side: compare against the oldest expected word
    always @(posedge i_clk) begin : check_words
        t_frame_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_byte %h last %b error %b",
                       out_ch.out_byte, out_ch.last, out_ch.error);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (out_ch.out_byte !== want.out_byte) begin
                    $error("out_byte mismatch: expected %h, actual %h",
                           want.out_byte, out_ch.out_byte);
                    errors++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last mismatch: expected %b, actual %b", want.last, out_ch.last);
                    errors++;
                end
                if (out_ch.error !== want.error) begin
                    $error("error mismatch: expected %b, actual %b", want.error, out_ch.error);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_items
        t_cmd_item it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 36)) begin
                it = pending_items.pop_front();
                in_ch.command_code <= it.command_code;
                in_ch.payload_len  <= it.payload_len;
                in_ch.reply_len    <= it.reply_len;
                in_ch.data_byte    <= it.data_byte;
                in_ch.valid        <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // hold the receiver off once, long enough to fill the job queue
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && inputs_taken >= 80 && pending_items.size() >= 10) begin
            hold_left <= 150;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 36);
    end

    task automatic write_address(input logic [ADDR_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        module_addr = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // fill < 0 gives random payload bytes, else every byte is fill
    task automatic add_packet(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] plen,
                              input logic [BYTE_W-1:0] rlen, input int fill,
                              output int n_items);
        t_cmd_item it;
        if (OVERHEAD_BYTES + plen > PACKET_BUFFER_BYTES ||
            OVERHEAD_BYTES + rlen > PACKET_BUFFER_BYTES || plen == '0)
            n_items = 1;
        else
            n_items = plen;
        for (int i = 0; i < n_items; i++) begin
            // later words carry random header fields, which must be ignored
            it.command_code = (i == 0) ? cmd  : BYTE_W'($urandom);
            it.payload_len  = (i == 0) ? plen : BYTE_W'($urandom);
            it.reply_len    = (i == 0) ? rlen : BYTE_W'($urandom);
            it.data_byte    = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            pending_items.push_back(it);
        end
    endtask

    task automatic add_random_packets(input int target);
        int added;
        int n;
        int r;
        logic [BYTE_W-1:0] plen;
        logic [BYTE_W-1:0] rlen;
        added = 0;
        while (added < target) begin
            r = $urandom_range(99);
            plen = (r < 20) ? 8'd0 : BYTE_W'($urandom_range(1, MAX_PAYLOAD));
            rlen = BYTE_W'($urandom_range(0, MAX_PAYLOAD));
            if (r < 4) begin
                plen = BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255));
            end else if (r < 8) begin
                rlen = BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255));
            end else if (r < 10) begin
                plen = BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255));
                rlen = BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255));
            end
            add_packet(BYTE_W'($urandom), plen, rlen, -1, n);
            added += n;
        end
    endtask

    task automatic drain(input int limit);
        int waited;
        waited = 0;
        while ((pending_items.size() != 0 || in_ch.valid || expected_words.size() != 0)
               && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    initial begin
        int n;
        in_ch.valid        = 1'b0;
        in_ch.command_code = '0;
        in_ch.payload_len  = '0;
        in_ch.reply_len    = '0;
        in_ch.data_byte    = '0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed packets under the reset address
        add_packet(8'h00, 8'd0, 8'd0, -1, n);
        add_packet(8'hFF, 8'd0, 8'(MAX_PAYLOAD), -1, n);
        add_packet(8'h00, 8'(MAX_PAYLOAD + 1), 8'd0, -1, n);
        add_packet(8'hFF, 8'd0, 8'(MAX_PAYLOAD + 1), -1, n);
        add_packet(8'hA5, 8'hFF, 8'hFF, -1, n);
        add_packet(8'h5A, 8'd1, 8'd0, 8'hFF, n);
        add_packet(8'hFF, 8'(MAX_PAYLOAD), 8'(MAX_PAYLOAD), 8'hFF, n);
        add_packet(8'h00, 8'd2, 8'd7, 8'h00, n);
        drain(20000);

        write_address(32'h0000_0000);
        add_random_packets(55);
        drain(20000);

        write_address(ADDR_W'($urandom));
        add_random_packets(55);
        drain(20000);

        write_address(32'hFFFF_FFFF);
        add_random_packets(55);
        drain(20000);

        write_address(ADDR_W'($urandom));
        add_random_packets(55);
        drain(20000);

        repeat (20) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            errors++;
        end
        if (errors == 0)
            $display("fingerprint_command_framer test passed");
        else
            $display("fingerprint_command_framer test failed");
        $finish;
    end

endmodule
